@@ hdl/per_note_pitch_channel_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// per_note_pitch_channel_allocator_top_macros
// Assertion macros shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef PER_NOTE_PITCH_CHANNEL_ALLOCATOR_TOP_MACROS_SVH
`define PER_NOTE_PITCH_CHANNEL_ALLOCATOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PNA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pna check failed");
// Next-cycle implication checked outside reset.
`define PNA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pna check failed");
`endif

@@ hdl/pna_pkg.sv @@
// ----------------------------------------------------------------------------
// pna_pkg
// Shared types and constants of the per-note pitch channel allocator.
// ----------------------------------------------------------------------------
package pna_pkg;

  localparam int NOTE_SLOTS_DEF = 32;
  localparam int CHANNELS_DEF   = 16;

  // Event opcodes.
  localparam logic [1:0] OP_OTHER = 2'd0;
  localparam logic [1:0] OP_ON    = 2'd1;
  localparam logic [1:0] OP_OFF   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPR  = 2'd0;
  localparam logic [1:0] REG_RANGE = 2'd1;
  localparam logic [1:0] REG_MASK  = 2'd2;

  // Bend limit per semitone, in 1/64 cent.
  localparam int SEMI_UNITS = 6400;
  localparam logic [8:0] EXPR_DIV = 9'd375;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the event, start the scan
    logic scan_step;  // look at the next slot
    logic div_start;  // set up the divider
    logic div_step;   // one quotient bit
    logic finish;     // update the table and show the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;
    logic div_last;
  } stat_t;

endpackage

@@ hdl/per_note_pitch_channel_allocator_top.sv @@
// ----------------------------------------------------------------------------
// per_note_pitch_channel_allocator_top
// Note event allocator for per-note tuning by expression or channel bend.
// ----------------------------------------------------------------------------
// Usage:
//   Present an event on opcode, note_id, note_channel and tuning_offset and
//   raise start while busy is low; the beat is taken at that edge.
//   Exactly one result beat follows, marked by done for one cycle; the
//   receiver cannot stall it, so it must take the beat when done is high.
//   Sequence: slot scan (one slot a cycle), serial division (one quotient bit
//   a cycle), a table update state, then the registered result. busy stays
//   high through scan, division and table update and is low again when done
//   is shown, so the next event can start in the cycle done is shown.
//   Configuration: cfg_we, cfg_index, cfg_data write a register at once;
//   any valid register write also frees every table slot. Write only while
//   busy is low.
//   Reset (rst, synchronous) clears registers, frees all slots and idles.
// ----------------------------------------------------------------------------
module per_note_pitch_channel_allocator_top #(
  parameter int NOTE_SLOTS = pna_pkg::NOTE_SLOTS_DEF,
  parameter int CHANNELS   = pna_pkg::CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] note_id,
  input  logic [3:0]         note_channel,
  input  logic signed [20:0] tuning_offset,
  output logic               done,
  output logic [3:0]         out_channel,
  output logic               tuning_cleared,
  output logic               expression_emit,
  output logic [15:0]        expression_value,
  output logic               bend_emit,
  output logic [3:0]         bend_channel,
  output logic [15:0]        bend_value
);

  pna_pkg::cmd_t  cmd;
  pna_pkg::stat_t stat;

  // Sequencer.
  pna_ctrl u_ctrl (
    .clk (clk), .rst (rst), .start (start), .stat (stat), .cmd (cmd), .busy (busy)
  );

  // Table, scan and divider.
  pna_datapath #(.NOTE_SLOTS(NOTE_SLOTS), .CHANNELS(CHANNELS)) u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .stat (stat),
    .cfg_we (cfg_we), .cfg_index (cfg_index), .cfg_data (cfg_data),
    .opcode (opcode), .note_id (note_id), .note_channel (note_channel),
    .tuning_offset (tuning_offset), .done (done), .out_channel (out_channel),
    .tuning_cleared (tuning_cleared), .expression_emit (expression_emit),
    .expression_value (expression_value), .bend_emit (bend_emit),
    .bend_channel (bend_channel), .bend_value (bend_value)
  );

endmodule

@@ hdl/pna_ctrl.sv @@
// ----------------------------------------------------------------------------
// pna_ctrl
// Sequencer: slot scan, serial division, then table update and result beat.
// ----------------------------------------------------------------------------
`include "per_note_pitch_channel_allocator_top_macros.svh"
module pna_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pna_pkg::stat_t  stat,
  output pna_pkg::cmd_t   cmd,
  output logic            busy
);

  pna_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pna_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pna_pkg::ST_IDLE: if (start) state_next = pna_pkg::ST_SCAN;
      pna_pkg::ST_SCAN: if (stat.scan_last) state_next = pna_pkg::ST_DIV;
      pna_pkg::ST_DIV:  if (stat.div_last) state_next = pna_pkg::ST_DONE;
      pna_pkg::ST_DONE: state_next = pna_pkg::ST_IDLE;
      default:          state_next = pna_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      pna_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      pna_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.div_start = stat.scan_last;
      end
      pna_pkg::ST_DIV:  cmd.div_step = 1'b1;
      pna_pkg::ST_DONE: cmd.finish = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  `PNA_ASSERT_NEXT(a_load_scan, cmd.load, state == pna_pkg::ST_SCAN)
  `PNA_ASSERT_NEXT(a_done_idle, cmd.finish, !busy)
  `PNA_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.scan_step, cmd.div_step, cmd.finish}))

endmodule

@@ hdl/pna_datapath.sv @@
// ----------------------------------------------------------------------------
// pna_datapath
// Slot table, sequential slot scan, serial divider and result register.
// ----------------------------------------------------------------------------
`include "per_note_pitch_channel_allocator_top_macros.svh"
module pna_datapath #(
  parameter int NOTE_SLOTS = pna_pkg::NOTE_SLOTS_DEF,
  parameter int CHANNELS   = pna_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pna_pkg::cmd_t       cmd,
  output pna_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  note_id,
  input  logic [3:0]          note_channel,
  input  logic signed [20:0]  tuning_offset,
  output logic                done,
  output logic [3:0]          out_channel,
  output logic                tuning_cleared,
  output logic                expression_emit,
  output logic [15:0]         expression_value,
  output logic                bend_emit,
  output logic [3:0]          bend_channel,
  output logic [15:0]         bend_value
);

  localparam int SW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  // Divider: numerator up to 2^20*128 + half divisor, 28 bits fits.
  localparam int NW = 29;
  localparam int DW = 12;

  // Configuration registers.
  logic        expr_mode;
  logic [6:0]  range;
  logic [15:0] mask;
  logic        cfg_hit;

  // Slot table.
  logic [NOTE_SLOTS-1:0] slot_valid;
  logic [30:0]           slot_note_id [NOTE_SLOTS];
  logic [NOTE_SLOTS-1:0] slot_chan_mode;
  logic [3:0]            slot_channel [NOTE_SLOTS];

  // Captured event.
  logic [1:0]  op_r;
  logic        id_ok;
  logic [30:0] id_r;
  logic [3:0]  nch_r;
  logic        neg_r;
  logic [20:0] mag_r;

  // Scan state.
  logic [SW-1:0]   scan_idx;
  logic            hit_found;
  logic [SW-1:0]   hit_idx;
  logic            free_found;
  logic [SW-1:0]   free_idx;
  logic [15:0]     used_ch;

  // Divider state.
  logic [NW-1:0] rem;
  logic [NW-1:0] quo;
  logic [DW-1:0] divisor;
  logic [4:0]    div_cnt;

  assign cfg_hit = cfg_we && (cfg_index == pna_pkg::REG_EXPR ||
                   cfg_index == pna_pkg::REG_RANGE || cfg_index == pna_pkg::REG_MASK);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      expr_mode <= 1'b0;
      range     <= '0;
      mask      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pna_pkg::REG_EXPR:  expr_mode <= cfg_data[0];
        pna_pkg::REG_RANGE: range <= cfg_data[6:0];
        pna_pkg::REG_MASK:  mask <= cfg_data;
        default:            expr_mode <= expr_mode;
      endcase
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      id_ok <= !note_id[31];
      id_r  <= note_id[30:0];
      nch_r <= note_channel;
      neg_r <= tuning_offset[20];
      mag_r <= tuning_offset[20] ? 21'(-tuning_offset) : tuning_offset;
    end
  end

  // Slot scan: one slot a cycle, collecting match, first free and used channels.
  assign stat.scan_last = (scan_idx == SW'(NOTE_SLOTS - 1));
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      used_ch    <= '0;
      hit_idx    <= '0;
      free_idx   <= '0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_last) scan_idx <= scan_idx + 1'b1;
      if (slot_valid[scan_idx]) begin
        if (!hit_found && slot_note_id[scan_idx] == id_r) begin
          hit_found <= 1'b1;
          hit_idx   <= scan_idx;
        end
        if (slot_chan_mode[scan_idx]) used_ch[slot_channel[scan_idx]] <= 1'b1;
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end
    end
  end

  // Lowest enabled free channel from 1 upward.
  logic       ch_found;
  logic [3:0] ch_pick;
  always_comb begin
    ch_found = 1'b0;
    ch_pick  = '0;
    for (int c = CHANNELS - 1; c >= 1; c--) begin
      if (mask[c] && !used_ch[c]) begin
        ch_found = 1'b1;
        ch_pick  = 4'(c);
      end
    end
  end

  // Bend range check.
  logic        in_range;
  logic [DW-1:0] bend_div;
  assign in_range = (range != 0) &&
                    ({5'd0, mag_r} <= 26'(range) * 26'(pna_pkg::SEMI_UNITS));
  assign bend_div = DW'(range) * DW'(25);

  // Restoring divider: (mag*mul + div/2) / div, one quotient bit a cycle.
  logic [NW-1:0] trial;
  assign stat.div_last = (div_cnt == 5'd0);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= expr_mode ? DW'(pna_pkg::EXPR_DIV) : bend_div;
      quo     <= expr_mode ? (NW'(mag_r) << 4) + NW'(pna_pkg::EXPR_DIV >> 1)
                           : (NW'(mag_r) << 7) + NW'(bend_div >> 1);
      rem     <= '0;
      div_cnt <= 5'(NW - 1);
    end else if (cmd.div_step) begin
      if (trial >= NW'(divisor)) begin
        rem <= trial - NW'(divisor);
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
    end
  end
  assign trial = {rem[NW-2:0], quo[NW-1]};

  // Normalize the quotient around centre with saturation.
  logic [15:0] norm;
  always_comb begin
    if (neg_r) norm = (quo >= NW'(32768)) ? 16'd0 : 16'(NW'(32768) - quo);
    else       norm = (quo >= NW'(32767)) ? 16'hFFFF : 16'(NW'(32768) + quo);
  end

  // Result decision.
  logic          is_on, is_off, bend_ok, remember;
  logic [SW-1:0] wr_idx;
  logic          wr_ok;
  assign is_on    = id_ok && op_r == pna_pkg::OP_ON;
  assign is_off   = id_ok && op_r == pna_pkg::OP_OFF;
  assign bend_ok  = is_on && !expr_mode && in_range && ch_found;
  assign remember = is_on && (expr_mode || bend_ok);
  assign wr_idx   = hit_found ? hit_idx : free_idx;
  assign wr_ok    = hit_found || free_found;

  // Table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cfg_hit) begin
      slot_valid <= '0;
    end else if (cmd.finish) begin
      if (remember && wr_ok) slot_valid[wr_idx] <= 1'b1;
      else if (is_off && hit_found) slot_valid[hit_idx] <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.finish && remember && wr_ok) begin
      slot_note_id[wr_idx]   <= id_r;
      slot_chan_mode[wr_idx] <= bend_ok;
      slot_channel[wr_idx]   <= bend_ok ? ch_pick : nch_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_channel      <= nch_r;
      tuning_cleared   <= 1'b0;
      expression_emit  <= 1'b0;
      expression_value <= '0;
      bend_emit        <= 1'b0;
      bend_channel     <= '0;
      bend_value       <= '0;
      if (is_on && expr_mode) begin
        tuning_cleared   <= 1'b1;
        expression_emit  <= 1'b1;
        expression_value <= norm;
      end else if (bend_ok) begin
        out_channel    <= ch_pick;
        tuning_cleared <= 1'b1;
        bend_emit      <= 1'b1;
        bend_channel   <= ch_pick;
        bend_value     <= norm;
      end else if (is_off && hit_found) begin
        tuning_cleared <= 1'b1;
        if (slot_chan_mode[hit_idx]) out_channel <= slot_channel[hit_idx];
      end
    end
  end

  `PNA_ASSERT_IMP(a_bend_chan, done && bend_emit, bend_channel != 4'd0 && bend_channel == out_channel)
  `PNA_ASSERT_IMP(a_emit_excl, done, !(bend_emit && expression_emit))
  `PNA_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

@@ test/pna_result_checker.sv @@
// ----------------------------------------------------------------------------
// pna_result_checker
// Watches the event and result beats of the allocator, keeps its own copy of
// the note table and registers, predicts each result and compares it.
// ----------------------------------------------------------------------------
module pna_result_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] note_id,
  input  logic [3:0]         note_channel,
  input  logic signed [20:0] tuning_offset,
  input  logic               done,
  input  logic [3:0]         out_channel,
  input  logic               tuning_cleared,
  input  logic               expression_emit,
  input  logic [15:0]        expression_value,
  input  logic               bend_emit,
  input  logic [3:0]         bend_channel,
  input  logic [15:0]        bend_value,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [3:0]  chan;
    logic        tclr;
    logic        xemit;
    logic [15:0] xval;
    logic        bemit;
    logic [3:0]  bch;
    logic [15:0] bval;
  } note_result_t;

  note_result_t expected_results[$];

  logic        expr_mode;
  logic [6:0]  bend_range;
  logic [15:0] chan_mask;
  logic        note_live[32];
  logic [30:0] note_key[32];
  logic        note_by_chan[32];
  logic [3:0]  note_chan[32];

  assign pending = expected_results.size();

  // Scale a tuning to a centered 16-bit value, rounding the magnitude.
  function automatic logic [15:0] scale_tuning(longint t, longint mul, longint dv);
    longint mag, off, v;
    mag = (t < 0) ? -t : t;
    off = (mag * mul + dv / 2) / dv;
    v = (t < 0) ? 32768 - off : 32768 + off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic int lookup_note(logic [30:0] key);
    for (int i = 0; i < 32; i++)
      if (note_live[i] && note_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void store_note(logic [30:0] key, logic by_chan, logic [3:0] ch);
    int s;
    s = lookup_note(key);
    if (s < 0) begin
      for (int i = 0; i < 32; i++)
        if (!note_live[i]) begin
          s = i;
          break;
        end
      if (s < 0) return;
    end
    note_live[s] = 1'b1;
    note_key[s] = key;
    note_by_chan[s] = by_chan;
    note_chan[s] = ch;
  endfunction

  function automatic int free_channel();
    logic taken;
    for (int ch = 1; ch < 16; ch++) begin
      if (!chan_mask[ch]) continue;
      taken = 1'b0;
      for (int i = 0; i < 32; i++)
        if (note_live[i] && note_by_chan[i] && note_chan[i] == ch) taken = 1'b1;
      if (!taken) return ch;
    end
    return -1;
  endfunction

  // Work out the result of one event and update the table.
  function automatic note_result_t allocate_note();
    note_result_t r;
    logic [30:0] key;
    longint t, mag;
    int ch, s;
    r = '0;
    r.chan = note_channel;
    key = note_id[30:0];
    t = tuning_offset;
    mag = (t < 0) ? -t : t;
    if (opcode == pna_pkg::OP_ON && !note_id[31]) begin
      if (expr_mode) begin
        r.tclr = 1'b1;
        r.xemit = 1'b1;
        r.xval = scale_tuning(t, 16, 375);
        store_note(key, 1'b0, note_channel);
      end else if (bend_range != 0 &&
                   mag <= longint'(bend_range) * pna_pkg::SEMI_UNITS) begin
        ch = free_channel();
        if (ch >= 0) begin
          r.chan = ch[3:0];
          r.tclr = 1'b1;
          r.bemit = 1'b1;
          r.bch = ch[3:0];
          r.bval = scale_tuning(t, 128, 25 * longint'(bend_range));
          store_note(key, 1'b1, ch[3:0]);
        end
      end
    end else if (opcode == pna_pkg::OP_OFF && !note_id[31]) begin
      s = lookup_note(key);
      if (s >= 0) begin
        r.tclr = 1'b1;
        if (note_by_chan[s]) r.chan = note_chan[s];
        note_live[s] = 1'b0;
      end
    end
    return r;
  endfunction

  // Track register writes, predict on each event beat, check each result beat.
  always @(posedge clk) begin
    note_result_t got, want;
    if (rst) begin
      expr_mode = 1'b0;
      bend_range = '0;
      chan_mask = '0;
      for (int i = 0; i < 32; i++) note_live[i] = 1'b0;
      fail_count <= 0;
    end else begin
      if (done) begin
        got = '{out_channel, tuning_cleared, expression_emit, expression_value,
                bend_emit, bend_channel, bend_value};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("result mismatch: expected %h actual %h", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_we && cfg_index <= pna_pkg::REG_MASK) begin
        case (cfg_index)
          pna_pkg::REG_EXPR:  expr_mode = cfg_data[0];
          pna_pkg::REG_RANGE: bend_range = cfg_data[6:0];
          default:            chan_mask = cfg_data;
        endcase
        for (int i = 0; i < 32; i++) note_live[i] = 1'b0;
      end
      if (start && !busy) expected_results.push_back(allocate_note());
    end
  end
endmodule

@@ test/tb_per_note_pitch_channel_allocator_top.sv @@
// ----------------------------------------------------------------------------
// tb_per_note_pitch_channel_allocator_top
// Drives note events through the allocator under several register settings,
// with random gaps between beats; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_per_note_pitch_channel_allocator_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic [1:0]         opcode = '0;
  logic signed [31:0] note_id = '0;
  logic [3:0]         note_channel = '0;
  logic signed [20:0] tuning_offset = '0;
  logic               done;
  logic [3:0]         out_channel;
  logic               tuning_cleared;
  logic               expression_emit;
  logic [15:0]        expression_value;
  logic               bend_emit;
  logic [3:0]         bend_channel;
  logic [15:0]        bend_value;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  int                 sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  per_note_pitch_channel_allocator_top i_dut (.*);

  pna_result_checker i_checker (.*);

  // Generous limit: all events with their gaps, several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("tb_per_note_pitch_channel_allocator_top NOT OK");
      $finish;
    end
  end

  // One register write, then cfg_we is lowered again before the next write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Present one event beat and hold it until taken. The block is busy right
  // after the beat, so the extra edge with start low costs no throughput.
  task automatic send_note(logic [1:0] op, logic signed [31:0] id, logic [3:0] ch,
                           logic signed [20:0] tun, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    start <= 1'b1;
    opcode <= op;
    note_id <= id;
    note_channel <= ch;
    tuning_offset <= tun;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  function automatic logic signed [20:0] rand_tuning(int range);
    int lim;
    case ($urandom_range(0, 5))
      0: return 21'sd819200;
      1: return -21'sd819200;
      2: return $signed(21'($urandom));
      default: begin
        lim = (range == 0 ? 1 : range) * pna_pkg::SEMI_UNITS;
        return 21'(int'($urandom_range(0, 2 * lim + 20)) - lim - 10);
      end
    endcase
  endfunction

  // Random phase: mostly random on and off events over a small id pool, plus noise.
  task automatic random_phase(int count, int range, bit allow_gap);
    logic [1:0] op;
    logic signed [31:0] id;
    for (int k = 0; k < count; k++) begin
      op = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
           : ($urandom_range(0, 1) ? pna_pkg::OP_ON : pna_pkg::OP_OFF);
      case ($urandom_range(0, 9))
        0: id = $signed($urandom);
        1: id = 32'sh7fffffff - $urandom_range(0, 3);
        default: id = $urandom_range(0, 40);
      endcase
      send_note(op, id, 4'($urandom), rand_tuning(range), allow_gap);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: expression mode extremes and table behavior.
    write_reg(pna_pkg::REG_EXPR, 16'd1);
    send_note(pna_pkg::OP_ON, 32'sd5, 4'd15, 21'sd819200, 1'b0);
    send_note(pna_pkg::OP_ON, 32'sd6, 4'd0, -21'sd819200, 1'b0);
    send_note(pna_pkg::OP_ON, 32'sd7, 4'd3, 21'sd0, 1'b0);
    send_note(pna_pkg::OP_ON, 32'sd5, 4'd2, 21'sd187, 1'b0);
    send_note(pna_pkg::OP_OFF, 32'sd5, 4'd9, 21'sd0, 1'b0);
    send_note(pna_pkg::OP_OFF, 32'sd99, 4'd9, 21'sd0, 1'b0);
    send_note(pna_pkg::OP_ON, -32'sd1, 4'd1, 21'sd64, 1'b0);
    send_note(pna_pkg::OP_OTHER, 32'sd7, 4'd4, 21'sd64, 1'b0);
    send_note(2'd3, 32'sd7, 4'd4, 21'sd64, 1'b0);
    for (int i = 0; i < 33; i++) send_note(pna_pkg::OP_ON, 100 + i, 4'd1, 21'sd1, 1'b0);
    send_note(pna_pkg::OP_OFF, 32'sd132, 4'd1, 21'sd0, 1'b0);
    drain();

    // Directed: channel mode, limit edges and running out of channels.
    write_reg(pna_pkg::REG_EXPR, 16'd0);
    write_reg(pna_pkg::REG_RANGE, 16'd2);
    write_reg(pna_pkg::REG_MASK, 16'hFFFF);
    send_note(pna_pkg::OP_ON, 32'sd1, 4'd0, 21'sd12800, 1'b0);
    send_note(pna_pkg::OP_ON, 32'sd2, 4'd0, -21'sd12800, 1'b0);
    send_note(pna_pkg::OP_ON, 32'sd3, 4'd0, 21'sd12801, 1'b0);
    for (int i = 0; i < 15; i++) send_note(pna_pkg::OP_ON, 10 + i, 4'd0, 21'sd100, 1'b0);
    send_note(pna_pkg::OP_OFF, 32'sd1, 4'd0, 21'sd0, 1'b0);
    drain();

    // Random phases across settings, extremes among them.
    write_reg(pna_pkg::REG_RANGE, 16'd127);
    write_reg(pna_pkg::REG_MASK, 16'h0001);
    random_phase(60, 127, 1'b1);
    drain();
    write_reg(pna_pkg::REG_MASK, 16'h0000);
    write_reg(pna_pkg::REG_RANGE, 16'd1);
    random_phase(50, 1, 1'b1);
    drain();
    for (int p = 0; p < 10; p++) begin
      int range;
      range = (p == 3) ? 96 : (p == 6 ? 0 : $urandom_range(1, 96));
      write_reg(pna_pkg::REG_EXPR, 16'($urandom_range(0, 1)));
      write_reg(pna_pkg::REG_RANGE, 16'(range));
      write_reg(pna_pkg::REG_MASK, (p == 0) ? 16'hFFFE : 16'($urandom));
      random_phase(120, range, p < 8);
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("tb_per_note_pitch_channel_allocator_top OK");
    end else begin
      $display("tb_per_note_pitch_channel_allocator_top NOT OK");
    end
    $finish;
  end
endmodule
